FILE: hw/rtl/point_affine_transform_defines.svh
// ----------------------------------------------------------------------------
// point_affine_transform_defines
// Assertion macros used by the point transform top level.
// ----------------------------------------------------------------------------
`ifndef POINT_AFFINE_TRANSFORM_DEFINES_SVH
`define POINT_AFFINE_TRANSFORM_DEFINES_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge out of reset
`define PAT_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("check failed");
// ante at one edge implies cons at the next edge
`define PAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`else
`define PAT_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define PAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/pat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_pkg
// Types, constants and helpers of the point transform pipeline.
// ----------------------------------------------------------------------------
package pat_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int ANG_BITS      = 30;

	localparam int ANG_SHIFT = ANG_BITS - FRACTION_BITS;
	localparam int MAG_W     = 32 + ANG_SHIFT;    // |angle| widened to Q30
	localparam int RED_STEPS = MAG_W - 33;        // quotient bits of mod 2*pi
	localparam int R_W       = MAG_W + 1;         // signed remainder
	localparam int ANG_W     = 34;                // CORDIC datapath width
	localparam int SHIFT_W   = $clog2(CORDIC_STAGES);
	localparam int PROD_W    = 65;                // 32 x 33 signed product
	localparam int WIDE_W    = 68;

	localparam longint TWO_PI_Q30 = 64'sd6746518852;

	localparam logic signed [R_W-1:0] PI_R      = R_W'(64'sd3373259426);
	localparam logic signed [R_W-1:0] TWO_PI_R  = R_W'(64'sd6746518852);
	localparam logic signed [R_W-1:0] HALF_PI_R = R_W'(64'sd1686629713);
	localparam logic signed [ANG_W-1:0] HALF_PI_A = ANG_W'(64'sd1686629713);
	localparam logic signed [ANG_W-1:0] GAIN_A    = ANG_W'(64'sd652032874);

	// atan(2^-i) in Q30
	localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
		34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768
	};

	typedef enum logic [3:0] {
		ACT_TRANSLATE = 4'd0,
		ACT_ROTX      = 4'd1,
		ACT_ROTY      = 4'd2,
		ACT_ROTZ      = 4'd3,
		ACT_SCALE     = 4'd4,
		ACT_REFLXY    = 4'd5,
		ACT_REFLYZ    = 4'd6,
		ACT_REFLZX    = 4'd7,
		ACT_SHEARZ    = 4'd8
	} action_t;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] pa;
		logic signed [31:0] pb;
		logic signed [31:0] pc;
	} item_t;

	typedef struct packed {
		item_t            it;
		logic             sign;
		logic [MAG_W-1:0] mag;
	} red_t;

	typedef struct packed {
		item_t                   it;
		logic                    neg;
		logic signed [ANG_W-1:0] ang;
		logic signed [ANG_W-1:0] cx;
		logic signed [ANG_W-1:0] cy;
	} cor_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic               ov;
	} sat_t;

	// 2*pi scaled for reduction step j (largest first)
	function automatic logic [MAG_W-1:0] red_modulus(input int j);
		red_modulus = MAG_W'(TWO_PI_Q30) << (RED_STEPS - 1 - j);
	endfunction

	function automatic sat_t sat32(input wide_t v);
		sat_t r;
		r.ov = !((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]));
		if (r.ov)
			r.v = v[WIDE_W-1] ? 32'sh80000000 : 32'sh7fffffff;
		else
			r.v = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/point_affine_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_affine_transform
// 3D affine point transform: translate, rotate, scale, reflect, shear.
// ----------------------------------------------------------------------------
// Usage:
//  - Point channel (pt_valid / pt_stall): one word per point carries the
//    action code, the point and up to three Q16.16 parameters.
//  - Result channel (res_valid / res_stall): one word per point, the
//    saturated point plus an overflow flag, in input order.
//  - Throughput: one point per cycle while res_stall is low.
//  - Path: every point word passes the row of 32 registers:
//    13 angle-reduction cells, one quadrant fold register, 16 CORDIC
//    cells, one multiply stage and one combine/output stage. Every
//    action travels the whole row so order is kept for free.
//  - Stall: each cell holds its word while the next one is full and
//    stalled; bubbles collapse, so input keeps flowing while the output
//    waits until the row fills up.
//  - Reset (arst_n low) empties the row; no state survives between points.
// ----------------------------------------------------------------------------
`include "point_affine_transform_defines.svh"

module point_affine_transform import pat_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pt_valid,
	output logic               pt_stall,
	input  logic [3:0]         action,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	input  logic signed [31:0] z_in,
	input  logic signed [31:0] param_a,
	input  logic signed [31:0] param_b,
	input  logic signed [31:0] param_c,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic signed [31:0] z_out,
	output logic               overflow
);

	// ---- input word: angle magnitude widened to Q30 ----
	red_t red_d [RED_STEPS+1];
	logic red_v [RED_STEPS+1];
	logic red_s [RED_STEPS+1];
	red_t red_in;
	logic [31:0] pa_abs;

	always_comb begin
		pa_abs = param_a[31] ? 32'(-param_a) : 32'(param_a);
		red_in.it.action = action_t'(action);
		red_in.it.x      = x_in;
		red_in.it.y      = y_in;
		red_in.it.z      = z_in;
		red_in.it.pa     = param_a;
		red_in.it.pb     = param_b;
		red_in.it.pc     = param_c;
		red_in.sign      = param_a[31];
		red_in.mag       = MAG_W'(pa_abs) << ANG_SHIFT;
	end

	assign red_d[0] = red_in;
	assign red_v[0] = pt_valid;
	assign pt_stall = red_s[0];

	// ---- reduction row: one quotient bit per cell ----
	for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
		pat_reduce_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.modulus  (red_modulus(j)),
			.up_valid (red_v[j]),
			.up_stall (red_s[j]),
			.up_data  (red_d[j]),
			.dn_valid (red_v[j+1]),
			.dn_stall (red_s[j+1]),
			.dn_data  (red_d[j+1])
		);
	end

	// ---- fold into [-pi/2, pi/2] and seed the CORDIC ----
	cor_t cor_d [CORDIC_STAGES+1];
	logic cor_v [CORDIC_STAGES+1];
	logic cor_s [CORDIC_STAGES+1];

	logic fold_valid_q;
	cor_t fold_q;
	cor_t fold_nxt;
	logic fold_adv;
	logic signed [R_W-1:0] r0, r1, r2;
	logic neg;

	assign fold_adv              = !fold_valid_q || !cor_s[0];
	assign red_s[RED_STEPS]      = !fold_adv;

	always_comb begin
		// remainder keeps the sign of the angle
		r0 = red_d[RED_STEPS].sign ? -$signed({1'b0, red_d[RED_STEPS].mag})
		                           :  $signed({1'b0, red_d[RED_STEPS].mag});
		r1 = r0;
		if (r0 > PI_R)
			r1 = r0 - TWO_PI_R;
		else if (r0 < -PI_R)
			r1 = r0 + TWO_PI_R;
		r2  = r1;
		neg = 1'b0;
		if (r1 > HALF_PI_R) begin
			r2  = r1 - PI_R;
			neg = 1'b1;
		end else if (r1 < -HALF_PI_R) begin
			r2  = r1 + PI_R;
			neg = 1'b1;
		end
		fold_nxt.it  = red_d[RED_STEPS].it;
		fold_nxt.neg = neg;
		fold_nxt.ang = r2[ANG_W-1:0];
		fold_nxt.cx  = GAIN_A;
		fold_nxt.cy  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fold_valid_q <= 1'b0;
		else if (fold_adv)
			fold_valid_q <= red_v[RED_STEPS];
	end

	always_ff @(posedge clk) begin
		if (fold_adv)
			fold_q <= fold_nxt;
	end

	assign cor_v[0] = fold_valid_q;
	assign cor_d[0] = fold_q;

	// ---- CORDIC row: one micro-rotation per cell ----
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
		pat_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (SHIFT_W'(i)),
			.atan     (ATAN_TAB[i]),
			.up_valid (cor_v[i]),
			.up_stall (cor_s[i]),
			.up_data  (cor_d[i]),
			.dn_valid (cor_v[i+1]),
			.dn_stall (cor_s[i+1]),
			.dn_data  (cor_d[i+1])
		);
	end

	// ---- products, combine, saturate, output register ----
	pat_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cor_v[CORDIC_STAGES]),
		.up_stall (cor_s[CORDIC_STAGES]),
		.up_data  (cor_d[CORDIC_STAGES]),
		.dn_valid (res_valid),
		.dn_stall (res_stall),
		.rx       (x_out),
		.ry       (y_out),
		.rz       (z_out),
		.ovf      (overflow)
	);

	// ---- checks ----
	logic fold_in_range;
	logic res_saturated;

	assign fold_in_range = fold_q.ang <= HALF_PI_A && fold_q.ang >= -HALF_PI_A;
	assign res_saturated = x_out == 32'sh7fffffff || x_out == 32'sh80000000 ||
	                       y_out == 32'sh7fffffff || y_out == 32'sh80000000 ||
	                       z_out == 32'sh7fffffff || z_out == 32'sh80000000;

	`PAT_ASSERT_NEXT(a_enter_row, clk, arst_n, pt_valid && !pt_stall, red_v[1])
	`PAT_ASSERT_ALWAYS(a_fold_range, clk, arst_n, !fold_valid_q || fold_in_range)
	`PAT_ASSERT_ALWAYS(a_ovf_sat, clk, arst_n, !res_valid || !overflow || res_saturated)

endmodule
`default_nettype wire

FILE: hw/rtl/pat_reduce_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_reduce_cell
// One restoring step of the angle reduction modulo 2*pi.
// ----------------------------------------------------------------------------
module pat_reduce_cell import pat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [MAG_W-1:0] modulus,
	input  logic             up_valid,
	output logic             up_stall,
	input  red_t             up_data,
	output logic             dn_valid,
	input  logic             dn_stall,
	output red_t             dn_data
);

	logic valid_q;
	red_t data_q;
	red_t nxt;
	logic adv;

	assign adv      = !valid_q || !dn_stall;
	assign up_stall = !adv;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		nxt = up_data;
		if (up_data.mag >= modulus)
			nxt.mag = up_data.mag - modulus;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			data_q <= nxt;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/pat_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_cordic_cell
// One rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module pat_cordic_cell import pat_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [SHIFT_W-1:0]      shift,
	input  logic signed [ANG_W-1:0] atan,
	input  logic                    up_valid,
	output logic                    up_stall,
	input  cor_t                    up_data,
	output logic                    dn_valid,
	input  logic                    dn_stall,
	output cor_t                    dn_data
);

	logic valid_q;
	cor_t data_q;
	cor_t nxt;
	logic adv;
	logic signed [ANG_W-1:0] xs;
	logic signed [ANG_W-1:0] ys;

	assign adv      = !valid_q || !dn_stall;
	assign up_stall = !adv;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		xs  = up_data.cx >>> shift;
		ys  = up_data.cy >>> shift;
		nxt = up_data;
		if (up_data.ang >= 0) begin
			nxt.cx  = up_data.cx - ys;
			nxt.cy  = up_data.cy + xs;
			nxt.ang = up_data.ang - atan;
		end else begin
			nxt.cx  = up_data.cx + ys;
			nxt.cy  = up_data.cy - xs;
			nxt.ang = up_data.ang + atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			data_q <= nxt;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/pat_arith.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_arith
// Multiply stage and combine/saturate stage; s2 is the output register.
// ----------------------------------------------------------------------------
module pat_arith import pat_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_stall,
	input  cor_t               up_data,
	output logic               dn_valid,
	input  logic               dn_stall,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic               ovf
);

	logic valid_s1, valid_s2;
	logic adv1, adv2;
	item_t it_s1;
	prod_t p_s1 [4];
	logic signed [31:0] rx_s2, ry_s2, rz_s2;
	logic ovf_s2;

	logic signed [ANG_W-1:0] cv, sv;
	logic signed [32:0] c33, s33;
	logic signed [31:0] a [4];
	logic signed [32:0] b [4];
	item_t it;

	assign adv2     = !valid_s2 || !dn_stall;
	assign adv1     = !valid_s1 || adv2;
	assign up_stall = !adv1;
	assign dn_valid = valid_s2;
	assign rx       = rx_s2;
	assign ry       = ry_s2;
	assign rz       = rz_s2;
	assign ovf      = ovf_s2;

	// operand select for the four multipliers
	always_comb begin
		it  = up_data.it;
		cv  = up_data.neg ? -up_data.cx : up_data.cx;
		sv  = up_data.neg ? -up_data.cy : up_data.cy;
		c33 = cv[32:0];
		s33 = sv[32:0];
		a[0] = it.x; a[1] = it.y; a[2] = it.z; a[3] = it.x;
		b[0] = {it.pa[31], it.pa};
		b[1] = {it.pb[31], it.pb};
		b[2] = {it.pc[31], it.pc};
		b[3] = c33;
		case (it.action)
			ACT_ROTX: begin
				a[0] = it.y; b[0] = c33;
				a[1] = it.z; b[1] = s33;
				a[2] = it.y; b[2] = s33;
				a[3] = it.z; b[3] = c33;
			end
			ACT_ROTY: begin
				a[0] = it.x; b[0] = c33;
				a[1] = it.z; b[1] = s33;
				a[2] = it.z; b[2] = c33;
				a[3] = it.x; b[3] = s33;
			end
			ACT_ROTZ: begin
				a[0] = it.x; b[0] = c33;
				a[1] = it.y; b[1] = s33;
				a[2] = it.x; b[2] = s33;
				a[3] = it.y; b[3] = c33;
			end
			ACT_SHEARZ: begin
				a[0] = it.z;
				a[1] = it.z;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			it_s1 <= it;
			for (int i = 0; i < 4; i++)
				p_s1[i] <= a[i] * b[i];
		end
	end

	// combine, shift back to Q16.16 and saturate
	wide_t wx, wy, wz, w0, w1, w2, w3;
	sat_t sx, sy, sz;

	always_comb begin
		w0 = wide_t'(p_s1[0]);
		w1 = wide_t'(p_s1[1]);
		w2 = wide_t'(p_s1[2]);
		w3 = wide_t'(p_s1[3]);
		wx = wide_t'(it_s1.x);
		wy = wide_t'(it_s1.y);
		wz = wide_t'(it_s1.z);
		case (it_s1.action)
			ACT_TRANSLATE: begin
				wx = wide_t'(it_s1.x) + wide_t'(it_s1.pa);
				wy = wide_t'(it_s1.y) + wide_t'(it_s1.pb);
				wz = wide_t'(it_s1.z) + wide_t'(it_s1.pc);
			end
			ACT_ROTX: begin
				wy = (w0 - w1) >>> ANG_BITS;
				wz = (w2 + w3) >>> ANG_BITS;
			end
			ACT_ROTY: begin
				wx = (w0 + w1) >>> ANG_BITS;
				wz = (w2 - w3) >>> ANG_BITS;
			end
			ACT_ROTZ: begin
				wx = (w0 - w1) >>> ANG_BITS;
				wy = (w2 + w3) >>> ANG_BITS;
			end
			ACT_SCALE: begin
				wx = w0 >>> FRACTION_BITS;
				wy = w1 >>> FRACTION_BITS;
				wz = w2 >>> FRACTION_BITS;
			end
			ACT_REFLXY: wz = -wide_t'(it_s1.z);
			ACT_REFLYZ: wx = -wide_t'(it_s1.x);
			ACT_REFLZX: wy = -wide_t'(it_s1.y);
			ACT_SHEARZ: begin
				wx = wide_t'(it_s1.x) + (w0 >>> FRACTION_BITS);
				wy = wide_t'(it_s1.y) + (w1 >>> FRACTION_BITS);
			end
			default: begin
			end
		endcase
		sx = sat32(wx);
		sy = sat32(wy);
		sz = sat32(wz);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			rx_s2  <= sx.v;
			ry_s2  <= sy.v;
			rz_s2  <= sz.v;
			ovf_s2 <= sx.ov || sy.ov || sz.ov;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1)
				valid_s1 <= up_valid;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

endmodule
`default_nettype wire
